>>> design/label_mean_color_fill_assert.svh
// ----------------------------------------------------------------------------
// label_mean_color_fill assertion macros
// Concurrent assertion shorthands, sampled on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LABEL_MEAN_COLOR_FILL_ASSERT_SVH
`define LABEL_MEAN_COLOR_FILL_ASSERT_SVH

// same-cycle implication
`define LMCF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lmcf assertion failed");

// next-cycle implication
`define LMCF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lmcf assertion failed");

`endif

>>> design/lmcf_pkg.sv
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lmcf_pkg;

    localparam int LABEL_SLOTS      = 64;
    localparam int PIXEL_COUNT_BITS = 20;

    localparam int LABEL_BITS      = $clog2(LABEL_SLOTS);
    localparam int COUNT_BITS      = PIXEL_COUNT_BITS + 1;
    localparam int CHAN_BITS       = 8;
    localparam int SUM_BITS        = PIXEL_COUNT_BITS + CHAN_BITS;
    localparam int QUO_BITS        = CHAN_BITS;
    localparam int STEP_BITS       = $clog2(QUO_BITS);
    localparam int NUM_LABELS_BITS = 7;
    localparam int IN_LABEL_BITS   = 6;
    localparam int KIND_BITS       = 2;

    localparam logic [NUM_LABELS_BITS-1:0] NUM_LABELS_RESET = NUM_LABELS_BITS'(49);

    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ACCUM = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

    localparam logic [0:0] ADDR_NUM_LABELS = 1'b0;

    typedef struct packed {
        logic [SUM_BITS-1:0]   sum_blue;
        logic [SUM_BITS-1:0]   sum_green;
        logic [SUM_BITS-1:0]   sum_red;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic write;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
    } status_t;

endpackage

>>> design/lmcf_ctrl.sv
// ----------------------------------------------------------------------------
// lmcf_ctrl
// Request sequencing: lookup, accumulate write, divide steps, result load.
// ----------------------------------------------------------------------------
module lmcf_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lmcf_pkg::KIND_BITS-1:0]   s_kind,
    input  lmcf_pkg::status_t                sts,
    output lmcf_pkg::cmd_t                   cmd
);
    import lmcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_QUERY,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.capture  = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority case (s_kind)
                        KIND_CLEAR: cmd.clear = 1'b1;
                        KIND_ACCUM: state_next = ST_ACCUM;
                        KIND_QUERY: state_next = ST_QUERY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACCUM: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QUERY: begin
                cmd.div_init = 1'b1;
                step_next    = STEP_BITS'(QUO_BITS - 1);
                state_next   = sts.hit ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_BITS'(1);
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> design/lmcf_dp.sv
// ----------------------------------------------------------------------------
// lmcf_dp
// Label entry memory with valid bits, accumulate adder, shared mean divider
// and result register.
// ----------------------------------------------------------------------------
module lmcf_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lmcf_pkg::cmd_t                         cmd,
    output lmcf_pkg::status_t                      sts,
    input  logic [lmcf_pkg::NUM_LABELS_BITS-1:0]   num_labels,
    input  logic [lmcf_pkg::IN_LABEL_BITS-1:0]     s_label,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_blue,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_green,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_red,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_blue,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_green,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_red,
    output logic                                   m_label_had_pixels
);
    import lmcf_pkg::*;

    entry_t                    mem [LABEL_SLOTS];
    logic [LABEL_SLOTS-1:0]    valid_reg;

    entry_t                    rd_reg;
    logic                      rd_valid_reg;
    logic [IN_LABEL_BITS-1:0]  label_reg;
    logic [CHAN_BITS-1:0]      blue_reg, green_reg, red_reg;

    logic [SUM_BITS-1:0]       rem_blue_reg, rem_green_reg, rem_red_reg;
    logic [SUM_BITS-1:0]       divisor_reg;
    logic [QUO_BITS-1:0]       quo_blue_reg, quo_green_reg, quo_red_reg;
    logic                      hit_reg;

    logic                      m_valid_reg;
    logic [CHAN_BITS-1:0]      out_blue_reg, out_green_reg, out_red_reg;
    logic                      out_had_reg;

    logic [LABEL_BITS-1:0]     idx_in, idx_cur;
    entry_t                    entry_cur, entry_sum;
    logic                      in_use, hit, can_add;

    function automatic logic [SUM_BITS+QUO_BITS-1:0] div_step_f(
        input logic [SUM_BITS-1:0] rem,
        input logic [SUM_BITS-1:0] dvs,
        input logic [QUO_BITS-1:0] quo
    );
        logic ge;
        ge = (rem >= dvs);
        return {ge ? rem - dvs : rem, quo[QUO_BITS-2:0], ge};
    endfunction

    assign idx_in    = LABEL_BITS'(s_label);
    assign idx_cur   = LABEL_BITS'(label_reg);
    assign entry_cur = rd_valid_reg ? rd_reg : '0;
    assign in_use    = ({1'b0, label_reg} < num_labels) &&
                       (32'(label_reg) < 32'(LABEL_SLOTS));
    assign hit       = in_use && (entry_cur.count != '0);
    assign can_add   = in_use && !entry_cur.count[PIXEL_COUNT_BITS];

    always_comb begin
        entry_sum.sum_blue  = entry_cur.sum_blue + SUM_BITS'(blue_reg);
        entry_sum.sum_green = entry_cur.sum_green + SUM_BITS'(green_reg);
        entry_sum.sum_red   = entry_cur.sum_red + SUM_BITS'(red_reg);
        entry_sum.count     = entry_cur.count + COUNT_BITS'(1);
    end

    assign sts.hit      = hit;
    assign sts.out_free = !m_valid_reg || m_ready;

    // entry memory: one read port at request capture, one write port
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_reg <= mem[idx_in];
        end
        if (cmd.write && can_add) begin
            mem[idx_cur] <= entry_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_valid_reg <= valid_reg[idx_in];
            label_reg    <= s_label;
            blue_reg     <= s_chan_blue;
            green_reg    <= s_chan_green;
            red_reg      <= s_chan_red;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear) begin
            valid_reg <= '0;
        end else if (cmd.write && can_add) begin
            valid_reg[idx_cur] <= 1'b1;
        end
    end

    // restoring divide, one quotient bit per step; mean always fits 8 bits
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_blue_reg  <= entry_cur.sum_blue;
            rem_green_reg <= entry_cur.sum_green;
            rem_red_reg   <= entry_cur.sum_red;
            divisor_reg   <= SUM_BITS'(entry_cur.count) << (QUO_BITS - 1);
            quo_blue_reg  <= '0;
            quo_green_reg <= '0;
            quo_red_reg   <= '0;
            hit_reg       <= hit;
        end else if (cmd.div_step) begin
            {rem_blue_reg, quo_blue_reg}   <= div_step_f(rem_blue_reg, divisor_reg,
                                                         quo_blue_reg);
            {rem_green_reg, quo_green_reg} <= div_step_f(rem_green_reg, divisor_reg,
                                                         quo_green_reg);
            {rem_red_reg, quo_red_reg}     <= div_step_f(rem_red_reg, divisor_reg,
                                                         quo_red_reg);
            divisor_reg <= divisor_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_blue_reg  <= hit_reg ? quo_blue_reg  : blue_reg;
            out_green_reg <= hit_reg ? quo_green_reg : green_reg;
            out_red_reg   <= hit_reg ? quo_red_reg   : red_reg;
            out_had_reg   <= hit_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_blue         = out_blue_reg;
    assign m_out_green        = out_green_reg;
    assign m_out_red          = out_red_reg;
    assign m_label_had_pixels = out_had_reg;

endmodule

>>> design/label_mean_color_fill.sv
// Clear and unused kinds complete on accept; accumulate does a memory read, then add/write.
// Query: for empty or unused labels, lookup, divider load and result load; otherwise
// lookup, divider load, 8 shared restoring-divide steps, result load.
// One request at a time; the next request is accepted once the last one has finished.
// Reset: num_labels = 49 and all label entries empty via per-entry valid flops,
// no clearing pass. A clear request empties all entries by resetting those flops.
// ----------------------------------------------------------------------------
// label_mean_color_fill
// Per-label color sums and pixel counts; query returns the label's mean color.
// ----------------------------------------------------------------------------
module label_mean_color_fill (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [0:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [lmcf_pkg::KIND_BITS-1:0]         s_kind,
    input  logic [lmcf_pkg::IN_LABEL_BITS-1:0]     s_label,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_blue,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_green,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         s_chan_red,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_blue,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_green,
    output logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_red,
    output logic                                   m_label_had_pixels
);
    import lmcf_pkg::*;

    logic [NUM_LABELS_BITS-1:0] num_labels_reg;
    cmd_t                       cmd;
    status_t                    sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NUM_LABELS) ? 32'(num_labels_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_labels_reg <= NUM_LABELS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_NUM_LABELS) begin
            num_labels_reg <= pwdata[NUM_LABELS_BITS-1:0];
        end
    end

    lmcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    lmcf_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .num_labels         (num_labels_reg),
        .s_label            (s_label),
        .s_chan_blue        (s_chan_blue),
        .s_chan_green       (s_chan_green),
        .s_chan_red         (s_chan_red),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_blue         (m_out_blue),
        .m_out_green        (m_out_green),
        .m_out_red          (m_out_red),
        .m_label_had_pixels (m_label_had_pixels)
    );

endmodule

>>> design/lmcf_checker.sv
// ----------------------------------------------------------------------------
// lmcf_checker
// Port-level checks on request sequencing and the result channel.
// ----------------------------------------------------------------------------
`include "label_mean_color_fill_assert.svh"

module lmcf_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [lmcf_pkg::KIND_BITS-1:0]         s_kind,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_blue,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_green,
    input  logic [lmcf_pkg::CHAN_BITS-1:0]         m_out_red,
    input  logic                                   m_label_had_pixels
);
    import lmcf_pkg::*;

    `LMCF_ASSERT_NEXT(a_busy_after_work,
        s_valid && s_ready && (s_kind == KIND_ACCUM || s_kind == KIND_QUERY), !s_ready)
    `LMCF_ASSERT_NEXT(a_idle_after_clear,
        s_valid && s_ready && s_kind != KIND_ACCUM && s_kind != KIND_QUERY, s_ready)
    `LMCF_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid)
    `LMCF_ASSERT_NEXT(a_result_stable, m_valid && !m_ready,
        $stable(m_out_blue) && $stable(m_out_green) && $stable(m_out_red) &&
        $stable(m_label_had_pixels))

endmodule

bind label_mean_color_fill lmcf_checker u_lmcf_checker (.*);
